// ----- rtl/core/crcg_pkg.sv -----
// Shared types and constants for the CRC generator and checker.
package crcg_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int DEG_W      = 6;
    localparam int CFG_W      = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic CMD_ENCODE   = 1'b0;
    localparam logic CMD_CHECK    = 1'b1;
    localparam logic KIND_CODE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic REG_GEN_POLY    = 1'b0;
    localparam logic REG_POLY_DEGREE = 1'b1;

    localparam logic [MAX_DEGREE-1:0] GEN_POLY_RST    = 32'h1;
    localparam logic [DEG_W-1:0]      POLY_DEGREE_RST = 6'd3;

    typedef struct packed {
        logic command;
        logic data_bit;
        logic last_bit;
    } t_in;

    typedef struct packed {
        logic result_kind;
        logic code_bit;
        logic error_found;
        logic end_of_packet;
    } t_out;

    typedef struct packed {
        t_out                  res;
        logic                  tail;
        logic [MAX_DEGREE-1:0] rem;
        logic [DEG_W-1:0]      deg;
    } t_job;

endpackage

// ----- rtl/core/crc_generate_and_check.sv -----
// Top level of the bit-serial CRC generator and checker.
//
// Input channel: one bit per beat (command, data_bit, last_bit), taken when
// push is high and full is low. The mode is taken from command on the first
// bit of a packet. Result channel: o_out holds the oldest result while empty
// is low; it is consumed when pop is high. Encode echoes every bit and after
// the last bit emits the degree check bits MSB first, the final one marked.
// Check emits one verdict beat on the last bit.
// A result passes from its input beat through the CRC update and queue write,
// then the output register. Throughput: one input beat per cycle while full
// is low; the output register delivers one beat per cycle while pop is high,
// so an encode tail of d check bits holds the back end and the 4-entry job
// queue fills, raising full until the tail drains.
// Configuration: i_cfg_we writes gen_poly (index 0) or poly_degree (index 1);
// write only while the block is idle.
// Reset (synchronous, i_rst_n low): queue and output emptied, CRC register
// cleared, polynomial 1 and degree 3. A stalled receiver holds the output
// beat; the queue then fills and full stops the sender.
module crc_generate_and_check
    import crcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in              i_in,
    output logic             empty,
    input  logic             pop,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic accept;
    logic job_we;
    t_job job_wr;
    t_job job_rd;
    logic job_empty;
    logic job_pop;

    assign accept = push && !full;

    crcg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_job_we   (job_we),
        .o_job      (job_wr)
    );

    crcg_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_we),
        .i_wr_data (job_wr),
        .i_rd      (job_pop),
        .o_rd_data (job_rd),
        .o_full    (full),
        .o_empty   (job_empty)
    );

    crcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_rd),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/core/crcg_front.sv -----
// Front end: accepts bits, holds configuration and runs the CRC shift register.
module crcg_front
    import crcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in              i_in,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_job_we,
    output t_job             o_job
);

    logic [MAX_DEGREE-1:0] r_poly, n_poly;
    logic [DEG_W-1:0]      r_deg, n_deg;
    logic [MAX_DEGREE-1:0] r_rem, n_rem;
    logic                  r_mode, n_mode;
    logic                  r_in_pkt, n_in_pkt;

    logic [DEG_W-1:0]      d;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] poly;
    logic [MAX_DEGREE-1:0] cur;
    logic [MAX_DEGREE-1:0] nxt;
    logic [4:0]            msb_idx;
    logic                  msb;
    logic                  mode;

    always_comb begin
        if (r_deg == '0) begin
            d = DEG_W'(1);
        end else if (r_deg > DEG_W'(MAX_DEGREE)) begin
            d = DEG_W'(MAX_DEGREE);
        end else begin
            d = r_deg;
        end
        if (d == DEG_W'(MAX_DEGREE)) begin
            mask = '1;
        end else begin
            mask = (MAX_DEGREE'(1) << d) - MAX_DEGREE'(1);
        end
        poly    = r_poly & mask;
        cur     = r_rem & mask;
        msb_idx = 5'(d - DEG_W'(1));
        msb     = cur[msb_idx];
        mode    = r_in_pkt ? r_mode : i_in.command;
        if (mode == CMD_ENCODE) begin
            nxt = ((cur << 1) & mask) ^ ((msb ^ i_in.data_bit) ? poly : '0);
        end else begin
            nxt = ((cur << 1) | MAX_DEGREE'(i_in.data_bit)) & mask;
            nxt = nxt ^ (msb ? poly : '0);
        end

        o_job.res.result_kind   = (mode == CMD_ENCODE) ? KIND_CODE : KIND_VERDICT;
        o_job.res.code_bit      = (mode == CMD_ENCODE) ? i_in.data_bit : 1'b0;
        o_job.res.error_found   = (mode == CMD_CHECK) && (nxt != '0);
        o_job.res.end_of_packet = (mode == CMD_CHECK);
        o_job.tail              = (mode == CMD_ENCODE) && i_in.last_bit;
        o_job.rem               = nxt;
        o_job.deg               = d;
        o_job_we = i_accept && ((mode == CMD_ENCODE) || i_in.last_bit);

        n_poly   = r_poly;
        n_deg    = r_deg;
        n_rem    = r_rem;
        n_mode   = r_mode;
        n_in_pkt = r_in_pkt;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GEN_POLY:    n_poly = i_cfg_data;
                REG_POLY_DEGREE: n_deg  = i_cfg_data[DEG_W-1:0];
                default:         n_poly = r_poly;
            endcase
        end
        if (i_accept) begin
            n_mode = mode;
            if (i_in.last_bit) begin
                n_rem    = '0;
                n_in_pkt = 1'b0;
            end else begin
                n_rem    = nxt;
                n_in_pkt = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly   <= GEN_POLY_RST;
            r_deg    <= POLY_DEGREE_RST;
            r_rem    <= '0;
            r_mode   <= CMD_ENCODE;
            r_in_pkt <= 1'b0;
        end else begin
            r_poly   <= n_poly;
            r_deg    <= n_deg;
            r_rem    <= n_rem;
            r_mode   <= n_mode;
            r_in_pkt <= n_in_pkt;
        end
    end

endmodule

// ----- rtl/core/crcg_fifo.sv -----
// Short job queue between the front and back ends.
module crcg_fifo
    import crcg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wr_data,
    input  logic i_rd,
    output t_job o_rd_data,
    output logic o_full,
    output logic o_empty
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, n_wp;
    logic [FIFO_AW-1:0] r_rp, n_rp;
    logic [FIFO_CW-1:0] r_cnt, n_cnt;
    logic               do_wr;
    logic               do_rd;

    assign o_full    = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_rd_data = r_mem[r_rp];

    always_comb begin
        do_wr = i_wr && !o_full;
        do_rd = i_rd && !o_empty;
        n_wp  = do_wr ? r_wp + FIFO_AW'(1) : r_wp;
        n_rp  = do_rd ? r_rp + FIFO_AW'(1) : r_rp;
        n_cnt = r_cnt + FIFO_CW'(do_wr) - FIFO_CW'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/crcg_back.sv -----
// Back end: emits result beats from queued jobs, serializing the check-bit tail.
module crcg_back
    import crcg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_job_empty,
    output logic o_job_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_out
);

    logic                  r_ov, n_ov;
    t_out                  r_out, n_out;
    logic [MAX_DEGREE-1:0] r_rem, n_rem;
    logic [DEG_W-1:0]      r_cnt, n_cnt;
    logic                  load;
    logic [4:0]            bit_idx;

    assign o_empty = !r_ov;
    assign o_out   = r_out;

    always_comb begin
        load      = !r_ov || i_pop;
        bit_idx   = 5'(r_cnt - DEG_W'(1));
        o_job_pop = 1'b0;
        n_ov      = r_ov;
        n_out     = r_out;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        if (load) begin
            if (r_cnt != '0) begin
                n_out.result_kind   = KIND_CODE;
                n_out.code_bit      = r_rem[bit_idx];
                n_out.error_found   = 1'b0;
                n_out.end_of_packet = (r_cnt == DEG_W'(1));
                n_cnt = r_cnt - DEG_W'(1);
                n_ov  = 1'b1;
            end else if (!i_job_empty) begin
                o_job_pop = 1'b1;
                n_out     = i_job.res;
                n_ov      = 1'b1;
                if (i_job.tail) begin
                    n_rem = i_job.rem;
                    n_cnt = i_job.deg;
                end
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_rem <= n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_ov  <= n_ov;
            r_cnt <= n_cnt;
        end
    end

endmodule
